>>> design/sha256_stream_hasher_defines.svh
// ----------------------------------------------------------------------------
// sha256_stream_hasher_defines
// assertion macros used by the checker file of the hasher
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// types, constants and round functions of the sha-256 stream hasher
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int WORD_W      = 32;
    localparam int HASH_WORDS  = 8;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_RND = 6'd63;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [HASH_WORDS-1:0][WORD_W-1:0] t_hash;

    // element 0 is h0
    localparam t_hash H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam t_word K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // controls towards the schedule window
    typedef struct packed {
        logic       push;
        logic [7:0] byte_val;
        logic       step;
    } t_sched_ctl;

    // controls towards the round unit
    typedef struct packed {
        logic       start;
        logic       step;
        logic       fold;
        logic       clear;
        logic [5:0] rnd;
    } t_round_ctl;

    function automatic t_word ror32(input t_word x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_word big_s0(input t_word x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic t_word big_s1(input t_word x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    function automatic t_word small_s0(input t_word x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_s1(input t_word x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> design/sha256_stream_hasher.sv
// input: a byte that does not complete a block is taken without a stall; a byte that
//   completes a block stalls the input through the 64 rounds of the one round unit
//   and the fold of the hash words that follows them
// end of message: the padding bytes (9 to 72 bytes) are pushed and each block is compressed,
//   then four digest transactions follow at one a cycle when downstream does not stall
// reset: synchronous, active low; hash words return to the initial values, no clearing pass
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// byte-serial sha-256 with one shared round unit under a small sequencer
// ----------------------------------------------------------------------------
module sha256_stream_hasher import shs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // message byte channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    // digest channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_part,
    output logic [1:0]  o_part_index,
    output logic        o_last_part,
    output logic        o_length_overflow
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // taking bytes
    localparam logic [2:0] S_ROUND = 3'd1;  // 64 compression rounds
    localparam logic [2:0] S_FOLD  = 3'd2;  // add working words into the hash
    localparam logic [2:0] S_PAD   = 3'd3;  // feeding padding and length bytes
    localparam logic [2:0] S_OUT   = 3'd4;  // presenting the digest

    localparam int CNT_W = 61;  // byte count; bit length is this shifted by three

    logic [2:0]       r_state, n_state;
    logic [5:0]       r_fill, n_fill;
    logic [CNT_W-1:0] r_byte_cnt, n_byte_cnt;
    logic             r_ovf, n_ovf;
    logic             r_pad, n_pad;          // padding still owed after this block
    logic             r_sent80, n_sent80;    // end marker byte already pushed
    logic             r_len_mode, n_len_mode;
    logic [2:0]       r_len_cnt, n_len_cnt;
    logic [63:0]      r_len_sr, n_len_sr;    // length bytes, most significant first
    logic             r_final, n_final;      // current block is the last one
    logic [5:0]       r_rnd, n_rnd;
    logic [1:0]       r_part, n_part;

    t_sched_ctl w_sched_ctl;
    t_round_ctl w_round_ctl;
    t_word      w_word;
    t_hash      w_hash;
    logic [2:0] w_hash_idx;

    shs_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (w_sched_ctl),
        .o_word (w_word)
    );

    shs_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_round_ctl),
        .i_word  (w_word),
        .o_hash  (w_hash)
    );

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_byte_cnt = r_byte_cnt;
        n_ovf      = r_ovf;
        n_pad      = r_pad;
        n_sent80   = r_sent80;
        n_len_mode = r_len_mode;
        n_len_cnt  = r_len_cnt;
        n_len_sr   = r_len_sr;
        n_final    = r_final;
        n_rnd      = r_rnd;
        n_part     = r_part;

        w_sched_ctl = '0;
        w_round_ctl = '0;
        w_round_ctl.rnd = r_rnd;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_byte_valid) begin
                        // a byte that would carry the bit length past 64 bits is dropped
                        if (&r_byte_cnt) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_byte_cnt           = r_byte_cnt + 1'b1;
                            w_sched_ctl.push     = 1'b1;
                            w_sched_ctl.byte_val = i_byte_value;
                        end
                    end
                    if (i_end_of_message) begin
                        n_pad      = 1'b1;
                        n_sent80   = 1'b0;
                        n_len_mode = 1'b0;
                        n_len_cnt  = '0;
                        n_len_sr   = {n_byte_cnt, 3'b000};
                    end
                    if (w_sched_ctl.push && r_fill == LAST_POS) begin
                        w_round_ctl.start = 1'b1;
                        n_rnd             = '0;
                        n_state           = S_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                w_sched_ctl.step = 1'b1;
                w_round_ctl.step = 1'b1;
                n_rnd            = r_rnd + 1'b1;
                if (r_rnd == LAST_RND) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                w_round_ctl.fold = 1'b1;
                if (r_final) begin
                    n_part  = '0;
                    n_state = S_OUT;
                end else if (r_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                w_sched_ctl.push = 1'b1;
                if (!r_sent80) begin
                    w_sched_ctl.byte_val = PAD_BYTE;
                    n_sent80             = 1'b1;
                end else if (r_len_mode || r_fill == LEN_POS) begin
                    w_sched_ctl.byte_val = r_len_sr[63:56];
                    n_len_sr             = {r_len_sr[55:0], 8'h00};
                    n_len_mode           = 1'b1;
                    n_len_cnt            = r_len_cnt + 1'b1;
                    if (&r_len_cnt) begin
                        n_final = 1'b1;
                        n_pad   = 1'b0;
                    end
                end else begin
                    w_sched_ctl.byte_val = 8'h00;
                end
                if (r_fill == LAST_POS) begin
                    w_round_ctl.start = 1'b1;
                    n_rnd             = '0;
                    n_state           = S_ROUND;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_part = r_part + 1'b1;
                    if (&r_part) begin
                        // back to the reset state for the next message
                        w_round_ctl.clear = 1'b1;
                        n_fill            = '0;
                        n_byte_cnt        = '0;
                        n_ovf             = 1'b0;
                        n_pad             = 1'b0;
                        n_final           = 1'b0;
                        n_state           = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // fill count wraps to zero as a block completes
        if (w_sched_ctl.push) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_byte_cnt <= '0;
            r_ovf      <= 1'b0;
            r_pad      <= 1'b0;
            r_sent80   <= 1'b0;
            r_len_mode <= 1'b0;
            r_len_cnt  <= '0;
            r_final    <= 1'b0;
            r_rnd      <= '0;
            r_part     <= '0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_byte_cnt <= n_byte_cnt;
            r_ovf      <= n_ovf;
            r_pad      <= n_pad;
            r_sent80   <= n_sent80;
            r_len_mode <= n_len_mode;
            r_len_cnt  <= n_len_cnt;
            r_final    <= n_final;
            r_rnd      <= n_rnd;
            r_part     <= n_part;
        end
        r_len_sr <= n_len_sr;
    end

    // digest transaction: hash words 2k and 2k+1, the hash holds still while shown
    assign w_hash_idx        = {r_part, 1'b0};
    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = (r_state == S_OUT);
    assign o_digest_part     = {w_hash[w_hash_idx], w_hash[w_hash_idx + 3'd1]};
    assign o_part_index      = r_part;
    assign o_last_part       = (r_part == 2'd3);
    assign o_length_overflow = r_ovf;

endmodule

>>> design/shs_sched.sv
// ----------------------------------------------------------------------------
// shs_sched
// block buffer that doubles as the sliding 16-word message schedule window
// ----------------------------------------------------------------------------
module shs_sched import shs_pkg::*; (
    input  logic       i_clk,
    input  t_sched_ctl i_ctl,
    output t_word      o_word
);

    localparam int BLK_W = BLOCK_BYTES * 8;

    logic [BLK_W-1:0] r_blk;
    logic [BLK_W-1:0] n_blk;
    t_word            w0;
    t_word            w1;
    t_word            w9;
    t_word            w14;
    t_word            w_new;

    // word t of the window sits at the top end, big-endian byte order
    assign w0  = r_blk[BLK_W-1            -: WORD_W];
    assign w1  = r_blk[BLK_W-1-WORD_W     -: WORD_W];
    assign w9  = r_blk[BLK_W-1-WORD_W*9   -: WORD_W];
    assign w14 = r_blk[BLK_W-1-WORD_W*14  -: WORD_W];

    assign w_new  = w0 + small_s0(w1) + w9 + small_s1(w14);
    assign o_word = w0;

    always_comb begin
        n_blk = r_blk;
        if (i_ctl.step) begin
            n_blk = {r_blk[BLK_W-WORD_W-1:0], w_new};
        end else if (i_ctl.push) begin
            n_blk = {r_blk[BLK_W-9:0], i_ctl.byte_val};
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
    end

endmodule

>>> design/shs_round.sv
// ----------------------------------------------------------------------------
// shs_round
// shared compression round unit with working and hash registers
// ----------------------------------------------------------------------------
module shs_round import shs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_round_ctl i_ctl,
    input  t_word      i_word,
    output t_hash      o_hash
);

    t_hash r_hash;
    t_hash n_hash;
    t_hash r_work;
    t_hash n_work;
    t_word t1;
    t_word t2;
    t_word ch;
    t_word maj;

    assign ch  = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
    assign maj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]);
    assign t1  = r_work[7] + big_s1(r_work[4]) + ch + K_TAB[i_ctl.rnd] + i_word;
    assign t2  = big_s0(r_work[0]) + maj;

    always_comb begin
        n_work = r_work;
        if (i_ctl.start) begin
            n_work = r_hash;
        end else if (i_ctl.step) begin
            n_work = {r_work[6], r_work[5], r_work[4], r_work[3] + t1,
                      r_work[2], r_work[1], r_work[0], t1 + t2};
        end
    end

    always_comb begin
        n_hash = r_hash;
        if (i_ctl.clear) begin
            n_hash = H_INIT;
        end else if (i_ctl.fold) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                n_hash[i] = r_hash[i] + r_work[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= H_INIT;
        end else begin
            r_hash <= n_hash;
        end
        r_work <= n_work;
    end

    assign o_hash = r_hash;

endmodule

>>> design/shs_checker.sv
// ----------------------------------------------------------------------------
// shs_checker
// port-level checks of the digest sequence of the stream hasher
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_defines.svh"

module shs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_byte_valid,
    input logic        i_end_of_message,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_part_index,
    input logic        o_last_part,
    input logic        o_length_overflow
);

    logic w_in_txn;
    logic w_out_txn;

    assign w_in_txn  = i_valid && !o_stall && (i_byte_valid || i_end_of_message);
    assign w_out_txn = o_valid && !i_stall;

    // parts follow one another in order
    `SHS_ASSERT_NEXT(a_part_order, w_out_txn && !o_last_part, o_valid && o_part_index == $past(o_part_index) + 2'd1, "digest parts out of order")

    // no message byte is taken while a digest is on offer
    `SHS_ASSERT_NOW(a_no_input_during_out, o_valid, o_stall, "input taken while digest pending")

    // the overflow flag is the same on every part of one digest
    `SHS_ASSERT_NEXT(a_ovf_steady, w_out_txn && !o_last_part, o_length_overflow == $past(o_length_overflow), "overflow flag changed within digest")

    // after the final part the block is ready for a new message
    `SHS_ASSERT_NEXT(a_idle_after_last, w_out_txn && o_last_part, !o_valid && !o_stall && !o_length_overflow, "not idle after final part")

    // any transaction that ends a message is followed by a stall while padding and compression run
    `SHS_ASSERT_NEXT(a_eom_busy, w_in_txn && i_end_of_message, o_stall, "end of message not processed")

endmodule

bind sha256_stream_hasher shs_checker u_checker (.*);
